// ===== sv/ecip_pkg.sv =====
// ---------------------------------------------------------------------------
// ecip_pkg
// Shared types and codes for the encoder correction interpolator.
// ---------------------------------------------------------------------------
package ecip_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned MIN_POINTS      = 3;
  localparam int unsigned COUNT_W         = 11;
  localparam int unsigned SLOT_W          = 10;
  localparam int unsigned OUT_W           = 41;

  localparam logic [1:0] ACT_WRITE    = 2'd0;
  localparam logic [1:0] ACT_VALIDATE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP   = 2'd2;
  localparam logic [1:0] ACT_SPARE    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_FEW      = 2'd2;
  localparam logic [1:0] ST_UNSORTED = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [SLOT_W-1:0]  point_slot;
    logic signed [31:0] point_position;
    logic signed [31:0] point_error;
    logic signed [31:0] raw_position;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] corrected_position;
    logic [1:0]              status;
  } result_t;

endpackage

// ===== sv/ecip_table.sv =====
// ---------------------------------------------------------------------------
// ecip_table
// Point table: position and error memories, one write and one registered read.
// ---------------------------------------------------------------------------
module ecip_table #(
  parameter int unsigned DEPTH = ecip_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [31:0]   wr_pos,
  input  logic signed [31:0]   wr_err,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [31:0]   rd_pos,
  output logic signed [31:0]   rd_err
);

  logic [31:0] pos_mem [DEPTH];
  logic [31:0] err_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      err_mem[wr_addr] <= wr_err;
    end
    rd_pos <= pos_mem[rd_addr];
    rd_err <= err_mem[rd_addr];
  end

endmodule

// ===== sv/ecip_muldiv.sv =====
// ---------------------------------------------------------------------------
// ecip_muldiv
// Serial multiply then restoring divide: q = a * b / d, quotient below 2^34.
// ---------------------------------------------------------------------------
module ecip_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] a,
  input  logic [31:0] b,
  input  logic [31:0] d,
  output logic        done,
  output logic [33:0] q
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

  mstate_t     state;
  logic [5:0]  cnt;
  logic [32:0] a_r;
  logic [31:0] b_sh;
  logic [31:0] d_r;
  logic [64:0] acc;
  logic [33:0] dlow;
  logic [33:0] rem;
  logic [64:0] acc_next;
  logic [33:0] r2;

  always_comb begin
    acc_next = {acc[63:0], 1'b0} + (b_sh[31] ? {32'd0, a_r} : 65'd0);
    r2       = {rem[32:0], dlow[33]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_sh  <= b;
            d_r   <= d;
            acc   <= '0;
            cnt   <= 6'd0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          acc  <= acc_next;
          b_sh <= {b_sh[30:0], 1'b0};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            rem   <= {3'd0, acc_next[64:34]};
            dlow  <= acc_next[33:0];
            q     <= '0;
            cnt   <= 6'd0;
            state <= M_DIV;
          end
        end
        M_DIV: begin
          dlow <= {dlow[32:0], 1'b0};
          if (r2 >= {2'd0, d_r}) begin
            rem <= r2 - {2'd0, d_r};
            q   <= {q[32:0], 1'b1};
          end else begin
            rem <= r2;
            q   <= {q[32:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd33) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/encoder_correction_interpolator_unit.sv =====
// Lookup runs a table search plus a 66-step multiply/divide. One word in
// flight; next word accepted once the result is handed to the output register.
// Rate is set by the single table read port and the serial multiply/divide
// unit. Synchronous reset clears flag, count and handshakes; table contents are
// undefined until written.
// ---------------------------------------------------------------------------
// encoder_correction_interpolator_unit
// Piecewise linear encoder correction over a memory-held point table.
// ---------------------------------------------------------------------------
module encoder_correction_interpolator_unit #(
  parameter int unsigned TABLE_DEPTH = ecip_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ecip_pkg::item_t               item_word,
  output logic                          result_valid,
  input  logic                          result_stall,
  output ecip_pkg::result_t             result_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ecip_pkg::COUNT_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_VAL_RD, S_VAL_CMP, S_LK_FIRST, S_LK_LAST, S_SRCH_RD, S_SRCH_CMP,
    S_FET_A, S_FET_B, S_FET_C, S_CALC, S_MULDIV, S_DONE
  } state_t;

  state_t                         state;
  logic [ecip_pkg::COUNT_W-1:0]   point_count;
  logic                           table_valid;
  logic signed [31:0]             x;
  logic [AW-1:0]                  idx, lo, hi, mid, last;
  logic signed [31:0]             prev, p1, e1, p2, e2;
  logic signed [ecip_pkg::OUT_W-1:0] err;
  logic [1:0]                     status;
  logic                           accept;
  logic                           wr_en;
  logic [AW-1:0]                  rd_addr;
  logic signed [31:0]             rd_pos, rd_err;
  logic [AW:0]                    mid_sum;
  logic signed [32:0]             dp, dx, de;
  logic [32:0]                    de_abs;
  logic                           md_start, md_done;
  logic [33:0]                    md_q;
  logic signed [35:0]             err_md;
  logic                           count_bad;
  logic                           out_load;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign last       = AW'(point_count - 11'd1);
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign count_bad  = (32'(point_count) < 32'(ecip_pkg::MIN_POINTS)) ||
                      (32'(point_count) > 32'(TABLE_DEPTH));
  assign wr_en      = accept && (item_word.action == ecip_pkg::ACT_WRITE) &&
                      (32'(item_word.point_slot) < 32'(TABLE_DEPTH));
  assign dp         = {p2[31], p2} - {p1[31], p1};
  assign dx         = {x[31], x} - {p1[31], p1};
  assign de         = {e2[31], e2} - {e1[31], e1};
  assign de_abs     = de[32] ? 33'(-de) : 33'(de);
  assign md_start   = (state == S_CALC) && !(dp <= 33'sd0 || dx < 33'sd0);
  assign err_md     = de[32] ? 36'(e1) - $signed({2'b0, md_q})
                             : 36'(e1) + $signed({2'b0, md_q});
  assign out_load   = (state == S_DONE) && (!result_valid || !result_stall);

  always_comb begin
    unique case (state)
      S_VAL_RD:   rd_addr = idx;
      S_LK_FIRST: rd_addr = last;
      S_SRCH_RD:  rd_addr = mid_sum[AW:1];
      S_FET_A:    rd_addr = lo - AW'(1);
      S_FET_B:    rd_addr = lo;
      default:    rd_addr = '0;
    endcase
  end

  ecip_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(item_word.point_slot)),
    .wr_pos  (item_word.point_position),
    .wr_err  (item_word.point_error),
    .rd_addr (rd_addr),
    .rd_pos  (rd_pos),
    .rd_err  (rd_err)
  );

  ecip_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (de_abs),
    .b     (32'(dx)),
    .d     (32'(dp)),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= '0;
      table_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        point_count <= cfg_data;
      end
      if ((cfg_valid && cfg_ready) || wr_en ||
          (accept && item_word.action == ecip_pkg::ACT_VALIDATE)) begin
        table_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            x      <= (item_word.action == ecip_pkg::ACT_LOOKUP) ?
                      item_word.raw_position : '0;
            err    <= '0;
            status <= ecip_pkg::ST_OK;
            idx    <= '0;
            priority case (item_word.action)
              ecip_pkg::ACT_WRITE: begin
                state <= S_DONE;
              end
              ecip_pkg::ACT_VALIDATE: begin
                if (count_bad) begin
                  status <= ecip_pkg::ST_FEW;
                  state  <= S_DONE;
                end else begin
                  state <= S_VAL_CMP;
                end
              end
              ecip_pkg::ACT_LOOKUP: begin
                if (!table_valid) begin
                  status <= ecip_pkg::ST_REFUSED;
                  state  <= S_DONE;
                end else begin
                  state <= S_LK_FIRST;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_VAL_RD: state <= S_VAL_CMP;
        S_VAL_CMP: begin
          prev <= rd_pos;
          if (idx != '0 && rd_pos < prev) begin
            status <= ecip_pkg::ST_UNSORTED;
            state  <= S_DONE;
          end else if (idx == last) begin
            table_valid <= 1'b1;
            state       <= S_DONE;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_VAL_RD;
          end
        end
        S_LK_FIRST: begin
          if (x <= rd_pos) begin
            err   <= ecip_pkg::OUT_W'(rd_err);
            state <= S_DONE;
          end else begin
            state <= S_LK_LAST;
          end
        end
        S_LK_LAST: begin
          if (x >= rd_pos) begin
            err   <= ecip_pkg::OUT_W'(rd_err);
            state <= S_DONE;
          end else begin
            lo    <= '0;
            hi    <= last;
            state <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          if (lo < hi) begin
            mid   <= mid_sum[AW:1];
            state <= S_SRCH_CMP;
          end else begin
            if (lo == '0) begin
              lo <= AW'(1);
            end
            state <= S_FET_A;
          end
        end
        S_SRCH_CMP: begin
          if (rd_pos < x) begin
            lo <= mid + AW'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SRCH_RD;
        end
        S_FET_A: state <= S_FET_B;
        S_FET_B: begin
          p1    <= rd_pos;
          e1    <= rd_err;
          state <= S_FET_C;
        end
        S_FET_C: begin
          p2    <= rd_pos;
          e2    <= rd_err;
          state <= S_CALC;
        end
        S_CALC: begin
          if (md_start) begin
            state <= S_MULDIV;
          end else begin
            err   <= ecip_pkg::OUT_W'(e1);
            state <= S_DONE;
          end
        end
        S_MULDIV: begin
          if (md_done) begin
            err   <= ecip_pkg::OUT_W'(err_md);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            result_word.status <= status;
            result_word.corrected_position <= (status == ecip_pkg::ST_OK) ?
              (ecip_pkg::OUT_W'(x) <<< 8) + err : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ecip_checker.sv =====
// ---------------------------------------------------------------------------
// ecip_checker
// Port-level checks for the encoder correction interpolator.
// ---------------------------------------------------------------------------
module ecip_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input ecip_pkg::result_t result_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result word dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second word accepted while one in flight");

  a_zero_fail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.status != ecip_pkg::ST_OK |->
    result_word.corrected_position == '0)
    else $error("nonzero position on a failed word");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind encoder_correction_interpolator_unit ecip_checker u_ecip_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_word  (result_word)
);

// ===== test/ecip_correction_checker.sv =====
// ---------------------------------------------------------------------------
// ecip_correction_checker
// Watches the item, config and result channels of the encoder correction
// interpolator. It keeps its own copy of the point table, the point count and
// the validated flag, works out the expected correction and status for each
// accepted word, and compares each result taken with the oldest expectation.
// ---------------------------------------------------------------------------
module ecip_correction_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  ecip_pkg::item_t               item_word,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  ecip_pkg::result_t             result_word,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ecip_pkg::COUNT_W-1:0]  cfg_data,
  output int                            errors,
  output int                            pending
);

  logic signed [31:0]           point_pos[ecip_pkg::TABLE_DEPTH_DEF];
  logic signed [31:0]           point_err[ecip_pkg::TABLE_DEPTH_DEF];
  bit                           table_ok;
  logic [ecip_pkg::COUNT_W-1:0] point_total;
  ecip_pkg::result_t            correction_q[$];

  function automatic longint signed interp_error(longint signed x);
    int unsigned n, lo, hi, mid;
    longint signed p1, p2, e1, e2, de, dp, dx;
    logic [127:0] prod, quot;
    n = point_total;
    if (x <= point_pos[0]) return point_err[0];
    if (x >= point_pos[n-1]) return point_err[n-1];
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (point_pos[mid] < x) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) lo = 1;
    p1 = point_pos[lo-1];
    p2 = point_pos[lo];
    e1 = point_err[lo-1];
    e2 = point_err[lo];
    dp = p2 - p1;
    dx = x - p1;
    if (dp <= 0 || dx < 0) return e1;
    de = e2 - e1;
    prod = 128'(de < 0 ? -de : de) * 128'(dx);
    quot = prod / 128'(dp);
    return de < 0 ? e1 - longint'(quot[63:0]) : e1 + longint'(quot[63:0]);
  endfunction

  function automatic ecip_pkg::result_t correct_word(ecip_pkg::item_t w);
    ecip_pkg::result_t r;
    bit sorted;
    longint signed v;
    r = '0;
    case (w.action)
      ecip_pkg::ACT_WRITE: begin
        point_pos[w.point_slot] = w.point_position;
        point_err[w.point_slot] = w.point_error;
        table_ok = 0;
      end
      ecip_pkg::ACT_VALIDATE: begin
        table_ok = 0;
        if (point_total < ecip_pkg::MIN_POINTS ||
            point_total > ecip_pkg::TABLE_DEPTH_DEF) begin
          r.status = ecip_pkg::ST_FEW;
        end else begin
          sorted = 1;
          for (int i = 1; i < point_total; i++)
            if (point_pos[i] < point_pos[i-1]) sorted = 0;
          if (sorted) table_ok = 1;
          else r.status = ecip_pkg::ST_UNSORTED;
        end
      end
      ecip_pkg::ACT_LOOKUP: begin
        if (!table_ok) begin
          r.status = ecip_pkg::ST_REFUSED;
        end else begin
          v = longint'(w.raw_position) * 256 + interp_error(w.raw_position);
          r.corrected_position = v[ecip_pkg::OUT_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    ecip_pkg::result_t want;
    if (rst) begin
      table_ok    = 0;
      point_total = '0;
      correction_q.delete();
      errors      = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (correction_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: pos %0d status %0d",
                     result_word.corrected_position, result_word.status);
        end else begin
          want = correction_q.pop_front();
          if (result_word.corrected_position !== want.corrected_position ||
              result_word.status !== want.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected pos %0d status %0d, got pos %0d status %0d",
                       want.corrected_position, want.status,
                       result_word.corrected_position, result_word.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        point_total = cfg_data;
        table_ok    = 0;
      end
      if (item_valid && !item_stall)
        correction_q = {correction_q, correct_word(item_word)};
    end
    pending = correction_q.size();
  end

endmodule

// ===== test/encoder_correction_interpolator_unit_tb.sv =====
// ---------------------------------------------------------------------------
// encoder_correction_interpolator_unit_tb
// Drives table writes, validations and lookups into the corrector, first a
// directed set of corner cases, then random tables and lookups under three
// idling patterns, with a 64-point table and one long output hold at the end.
// ---------------------------------------------------------------------------
module encoder_correction_interpolator_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                         clk;
  logic                         rst;
  logic                         item_valid;
  logic                         item_stall;
  ecip_pkg::item_t              item_word;
  logic                         result_valid;
  logic                         result_stall;
  ecip_pkg::result_t            result_word;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [ecip_pkg::COUNT_W-1:0] cfg_data;

  int            errors;
  int            pending;
  int            sent;
  int            send_idle;
  int            recv_idle;
  bit            want_hold;
  bit            hold_done;
  int            hold_left;
  int            quiet_cycles;
  longint signed table_pos[$];

  encoder_correction_interpolator_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item_word(item_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_word(result_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ecip_correction_checker u_checker (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item_word(item_word),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_word(result_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 0;
      hold_left    <= 0;
      hold_done    <= 0;
    end else if (hold_left > 0) begin
      result_stall <= 1;
      hold_left    <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      result_stall <= 1;
      hold_left    <= 400;
      hold_done    <= 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("encoder_correction_interpolator_unit_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] act, logic [ecip_pkg::SLOT_W-1:0] slot,
                      logic [31:0] pos, logic [31:0] err, logic [31:0] raw);
    ecip_pkg::item_t w;
    w.action         = act;
    w.point_slot     = slot;
    w.point_position = pos;
    w.point_error    = err;
    w.raw_position   = raw;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    item_word  <= w;
    do @(posedge clk); while (!(item_valid && !item_stall));
    sent++;
  endtask

  task automatic write_count(logic [ecip_pkg::COUNT_W-1:0] n);
    item_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_error();
    if ($urandom_range(1)) return $urandom;
    return 32'($signed($urandom_range(4000)) - 2000);
  endfunction

  // load points 0..n-1, sorted unless told otherwise
  task automatic load_table(int n, bit sorted);
    bit coarse;
    int j;
    longint signed t;
    coarse = ($urandom_range(3) == 0);
    table_pos.delete();
    for (int i = 0; i < n; i++)
      table_pos = {table_pos, (coarse ? longint'($urandom_range(12)) * 1000 - 6000
                                      : longint'($signed($urandom)))};
    if (sorted) table_pos.sort();
    else if (n > 1) begin
      table_pos.sort();
      j = $urandom_range(n - 2);
      t = table_pos[j];
      table_pos[j] = table_pos[j+1] + 1;
      table_pos[j+1] = t;
    end
    for (int i = 0; i < n; i++)
      send(ecip_pkg::ACT_WRITE, ecip_pkg::SLOT_W'(i), 32'(table_pos[i]), rand_error(),
           $urandom);
  endtask

  task automatic lookup_near();
    int i;
    longint signed span;
    if (table_pos.size() < 2 || $urandom_range(2) == 0) begin
      send(ecip_pkg::ACT_LOOKUP, ecip_pkg::SLOT_W'($urandom), $urandom, $urandom,
           $urandom);
    end else begin
      i = $urandom_range(table_pos.size() - 2);
      span = table_pos[i+1] - table_pos[i];
      send(ecip_pkg::ACT_LOOKUP, ecip_pkg::SLOT_W'($urandom), $urandom, $urandom,
           32'(table_pos[i] + (span > 0 ? longint'({$urandom, $urandom} % span) : 0)));
    end
  endtask

  task automatic random_block();
    int n;
    int r;
    r = $urandom_range(19);
    if (r == 0) n = $urandom_range(2);
    else if (r == 1) n = 40 + $urandom_range(30);
    else if (r == 2) n = 1025 + $urandom_range(1022);
    else n = 3 + $urandom_range(10);
    write_count(ecip_pkg::COUNT_W'(n));
    if (n <= ecip_pkg::TABLE_DEPTH_DEF) load_table(n, $urandom_range(6) != 0);
    else table_pos.delete();
    send(ecip_pkg::ACT_VALIDATE, ecip_pkg::SLOT_W'($urandom), $urandom, $urandom,
         $urandom);
    repeat ($urandom_range(5, 15)) begin
      r = $urandom_range(19);
      if (r == 0) begin
        send(ecip_pkg::ACT_SPARE, ecip_pkg::SLOT_W'($urandom), $urandom, $urandom,
             $urandom);
      end else if (r == 1) begin
        send(ecip_pkg::ACT_WRITE, ecip_pkg::SLOT_W'($urandom), $urandom, rand_error(),
             $urandom);
        lookup_near();
        if (n <= ecip_pkg::TABLE_DEPTH_DEF || $urandom_range(1))
          send(ecip_pkg::ACT_VALIDATE, ecip_pkg::SLOT_W'($urandom), $urandom,
               $urandom, $urandom);
      end else begin
        lookup_near();
      end
    end
  endtask

  initial begin
    rst          = 1;
    item_valid   = 0;
    item_word    = '0;
    cfg_valid    = 0;
    cfg_data     = '0;
    want_hold    = 0;
    send_idle    = 0;
    recv_idle    = 0;
    sent         = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_count('0);
    send(ecip_pkg::ACT_VALIDATE, '0, '0, '0, '0);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, 32'h7FFF_FFFF);
    send(ecip_pkg::ACT_SPARE, '1, '1, '1, '1);
    write_count('1);
    send(ecip_pkg::ACT_VALIDATE, '0, '0, '0, '0);
    write_count(ecip_pkg::COUNT_W'(ecip_pkg::MIN_POINTS));
    send(ecip_pkg::ACT_WRITE, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send(ecip_pkg::ACT_WRITE, 10'd1, 32'h0000_0000, 32'h8000_0000, '0);
    send(ecip_pkg::ACT_WRITE, 10'd2, 32'h7FFF_FFFF, 32'h0000_0000, '0);
    send(ecip_pkg::ACT_VALIDATE, '0, '0, '0, '0);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, 32'h8000_0000);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, 32'h7FFF_FFFF);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, -32'sd5);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, 32'd5);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, 32'd0);
    send(ecip_pkg::ACT_SPARE, '0, '0, '0, '0);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, 32'd12345);
    send(ecip_pkg::ACT_WRITE, 10'd1023, '1, '1, '0);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, 32'd7);
    send(ecip_pkg::ACT_VALIDATE, '0, '0, '0, '0);
    send(ecip_pkg::ACT_WRITE, 10'd1, 32'h8000_0000, 32'd100, '0);
    send(ecip_pkg::ACT_WRITE, 10'd2, -32'sd1, 32'd0, '0);
    send(ecip_pkg::ACT_VALIDATE, '0, '0, '0, '0);
    send(ecip_pkg::ACT_WRITE, 10'd1, 32'h0000_0000, 32'd100, '0);
    send(ecip_pkg::ACT_VALIDATE, '0, '0, '0, '0);
    send(ecip_pkg::ACT_LOOKUP, '0, '0, '0, 32'hC000_0000);

    send_idle = 12;
    recv_idle = 49;
    while (sent < 120) random_block();
    send_idle = 49;
    recv_idle = 12;
    while (sent < 220) random_block();
    send_idle = 0;
    recv_idle = 0;
    while (sent < 300) random_block();

    write_count(ecip_pkg::COUNT_W'(64));
    load_table(64, 1);
    send(ecip_pkg::ACT_VALIDATE, '0, '0, '0, '0);
    want_hold <= 1;
    repeat (30) lookup_near();

    item_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("encoder_correction_interpolator_unit_tb OK");
    else
      $display("encoder_correction_interpolator_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ecip_pkg.sv
sv/ecip_table.sv
sv/ecip_muldiv.sv
sv/encoder_correction_interpolator_unit.sv
sv/ecip_checker.sv
test/ecip_correction_checker.sv
test/encoder_correction_interpolator_unit_tb.sv
